### hw/rtl/cleb_pkg.sv
`timescale 1ns / 1ps

package cleb_pkg;

    localparam int CAPACITY   = 32;
    localparam int CAP_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int AMT_W      = 9;
    localparam int MV_W       = ((CAP_W > AMT_W) ? CAP_W : AMT_W) + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] EOL_BYTE = 8'd10;

    typedef enum logic [1:0] {
        KIND_TYPE  = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_BKSP  = 2'd2,
        KIND_PRINT = 2'd3
    } kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_PRINT
    } back_state_t;

    typedef struct packed {
        kind_t                    op;
        logic [7:0]               ch;
        logic signed [AMT_W-1:0]  amount;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    typedef struct packed {
        logic [CAP_W-1:0] len;
        logic [CAP_W-1:0] cursor;
        logic             printing;
    } back_status_t;

endpackage

### hw/rtl/cleb_if.sv
`timescale 1ns / 1ps

interface cleb_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [7:0]        ch;
    logic signed [8:0] amount;

    modport source (output valid, kind, ch, amount, input ready);
    modport sink   (input valid, kind, ch, amount, output ready);
endinterface

interface cleb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

### hw/rtl/cleb_front.sv
`timescale 1ns / 1ps

module cleb_front
    import cleb_pkg::*;
(
    cleb_in_if.sink      cmd,
    input  fifo_status_t fifo_status,
    output logic         push,
    output cmd_t         push_cmd
);

    always_comb
    begin
        cmd.ready       = !fifo_status.full;
        push            = cmd.valid && !fifo_status.full;
        push_cmd.ch     = cmd.ch;
        push_cmd.amount = cmd.amount;
        case (cmd.kind)
            KIND_TYPE: push_cmd.op = KIND_TYPE;
            KIND_MOVE: push_cmd.op = KIND_MOVE;
            KIND_BKSP: push_cmd.op = KIND_BKSP;
            default:   push_cmd.op = KIND_PRINT;
        endcase
    end

endmodule

### hw/rtl/cleb_fifo.sv
`timescale 1ns / 1ps

module cleb_fifo
    import cleb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  cmd_t         push_cmd,
    input  logic         pop,
    output cmd_t         head_cmd,
    output fifo_status_t status
);

    cmd_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next  = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
        status.empty = (count_reg == '0);
        status.full  = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
        head_cmd     = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/cleb_back.sv
`timescale 1ns / 1ps

module cleb_back
    import cleb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         head_cmd,
    input  fifo_status_t fifo_status,
    output logic         pop,
    output back_status_t status,
    cleb_out_if.source   result
);

    back_state_t state_reg, state_next;

    logic [7:0]       cell_reg [CAPACITY];
    logic [7:0]       cell_next [CAPACITY];
    logic [7:0]       cell_prev [CAPACITY];
    logic [7:0]       cell_succ [CAPACITY];
    logic [CAP_W-1:0] len_reg, len_next;
    logic [CAP_W-1:0] cursor_reg, cursor_next;
    logic [CAP_W-1:0] cursor_m1;
    logic [CAP_W-1:0] pr_idx_reg, pr_idx_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             slot_free;
    logic             load;

    logic signed [MV_W-1:0] mv_sum;
    logic signed [MV_W-1:0] mv_len;

    always_comb
    begin
        cell_prev[0]          = head_cmd.ch;
        cell_succ[CAPACITY-1] = cell_reg[CAPACITY-1];
        for (int i = 1; i < CAPACITY; i++)
        begin
            cell_prev[i] = cell_reg[i-1];
        end
        for (int i = 0; i < CAPACITY - 1; i++)
        begin
            cell_succ[i] = cell_reg[i+1];
        end
    end

    always_comb
    begin
        mv_sum    = $signed({{(MV_W - CAP_W){1'b0}}, cursor_reg})
                  + $signed({{(MV_W - AMT_W){head_cmd.amount[AMT_W-1]}}, head_cmd.amount});
        mv_len    = $signed({{(MV_W - CAP_W){1'b0}}, len_reg});
        cursor_m1 = cursor_reg - 1'b1;
        slot_free = !out_valid_reg || result.ready;

        state_next     = state_reg;
        len_next       = len_reg;
        cursor_next    = cursor_reg;
        pr_idx_next    = pr_idx_reg;
        pop            = 1'b0;
        load           = 1'b0;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !result.ready;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_status.empty)
                begin
                    pop = 1'b1;
                    case (head_cmd.op)
                        KIND_TYPE:
                        begin
                            if (len_reg < CAP_W'(CAPACITY))
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (CAP_W'(i) > cursor_reg)
                                        cell_next[i] = cell_prev[i];
                                    else if (CAP_W'(i) == cursor_reg)
                                        cell_next[i] = head_cmd.ch;
                                end
                                len_next    = len_reg + 1'b1;
                                cursor_next = cursor_reg + 1'b1;
                            end
                        end
                        KIND_MOVE:
                        begin
                            if (mv_sum < 0)
                                cursor_next = '0;
                            else if (mv_sum > mv_len)
                                cursor_next = len_reg;
                            else
                                cursor_next = mv_sum[CAP_W-1:0];
                        end
                        KIND_BKSP:
                        begin
                            if (cursor_reg != '0)
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (CAP_W'(i) >= cursor_m1)
                                        cell_next[i] = cell_succ[i];
                                end
                                len_next    = len_reg - 1'b1;
                                cursor_next = cursor_m1;
                            end
                        end
                        default:
                        begin
                            state_next  = BK_PRINT;
                            pr_idx_next = '0;
                        end
                    endcase
                end
            end
            BK_PRINT:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    if (pr_idx_reg < len_reg)
                    begin
                        out_byte_next = cell_reg[pr_idx_reg[IDX_W-1:0]];
                        out_last_next = 1'b0;
                        pr_idx_next   = pr_idx_reg + 1'b1;
                    end
                    else
                    begin
                        out_byte_next = EOL_BYTE;
                        out_last_next = 1'b1;
                        state_next    = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end

        status.len      = len_reg;
        status.cursor   = cursor_reg;
        status.printing = (state_reg == BK_PRINT);

        result.valid    = out_valid_reg;
        result.out_byte = out_byte_reg;
        result.last     = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            len_reg       <= '0;
            cursor_reg    <= '0;
            pr_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cursor_reg    <= cursor_next;
            pr_idx_reg    <= pr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

endmodule

### hw/rtl/cursor_line_edit_buffer.sv
`timescale 1ns / 1ps

// Line-edit buffer of CAPACITY bytes with a cursor. Commands enter a
// four-deep queue; the executing side holds the text in a row of byte cells
// that shift right on type and left on backspace, so type, move and
// backspace each retire as they are dequeued and can arrive back to back.
// A print is dequeued, then holds the executing side as it makes one result
// transfer per cycle while the sink is ready, through a registered output
// as a counter walks the cells, then an end-of-line byte marked last; the
// queue keeps accepting commands meanwhile until it fills. A full buffer drops
// typed bytes; moves clamp to the text; backspace at the start does nothing.

module cursor_line_edit_buffer
    import cleb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cleb_in_if.sink    cmd,
    cleb_out_if.source result
);

    fifo_status_t fifo_status;
    back_status_t back_status;
    cmd_t         push_cmd;
    cmd_t         head_cmd;
    logic         push;
    logic         pop;

    cleb_front u_front (
        .cmd         (cmd),
        .fifo_status (fifo_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    cleb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (fifo_status)
    );

    cleb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .fifo_status (fifo_status),
        .pop         (pop),
        .status      (back_status),
        .result      (result)
    );

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.len <= CAP_W'(CAPACITY))
        else $error("text length above capacity");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.cursor <= back_status.len)
        else $error("cursor past end of text");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |-> !fifo_status.full)
        else $error("command accepted into full queue");

    a_no_pop_printing: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.printing |-> !pop)
        else $error("queue popped during print");

endmodule
